>>> rtl/core/jqrlc_pkg.sv
package jqrlc_pkg;

	// Field widths
	localparam int COEF_W     = 12;
	localparam int STEP_W     = 8;
	localparam int COMP_W     = 2;
	localparam int RUN_W      = 4;
	localparam int AMP_W      = 13;
	localparam int TBL_IDX_W  = 6;
	localparam int TBL_ADDR_W = TBL_IDX_W + 1;
	localparam int TBL_DEPTH  = 2 ** TBL_ADDR_W;

	// Default geometry
	localparam int BLOCK_COEFFS_DEF   = 64;
	localparam int NUM_COMPONENTS_DEF = 3;

	// Run-length codes
	localparam logic [RUN_W-1:0] ZRL_RUN  = 4'hf;
	localparam int               ZRL_SPAN = 16;

	// Function codes of an input item
	localparam logic FUNC_TABLE = 1'b0;
	localparam logic FUNC_COEF  = 1'b1;

	// Component codes
	localparam logic [COMP_W-1:0] COMP_LUMA = 2'd0;

	// Controller to datapath commands
	typedef struct packed {
		logic tbl_wr;    // write quantization table entry
		logic capture;   // latch coefficient and component, start table read
		logic div_load;  // load divider with coefficient and table entry
		logic emit_zrl;  // send one sixteen-zero run pair
		logic finish;    // send final pair of this coefficient, if any, and advance
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic div_busy;
		logic dc;
		logic q_zero;
		logic zrl_pending;
		logic out_free;
	} status_t;

endpackage

>>> rtl/core/jqrlc_item_if.sv
interface jqrlc_item_if import jqrlc_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     func;
	logic [COMP_W-1:0]        component;
	logic [TBL_IDX_W-1:0]     table_position;
	logic [STEP_W-1:0]        quant_step;
	logic signed [COEF_W-1:0] coefficient;

	modport source (
		output valid, func, component, table_position, quant_step, coefficient,
		input  ready
	);
	modport sink (
		input  valid, func, component, table_position, quant_step, coefficient,
		output ready
	);
endinterface

>>> rtl/core/jqrlc_result_if.sv
interface jqrlc_result_if import jqrlc_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [RUN_W-1:0]        run_length;
	logic signed [AMP_W-1:0] amplitude;
	logic                    block_end;

	modport source (
		output valid, run_length, amplitude, block_end,
		input  ready
	);
	modport sink (
		input  valid, run_length, amplitude, block_end,
		output ready
	);
endinterface

>>> rtl/core/jqrlc_ram.sv
module jqrlc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/jqrlc_divider.sv
module jqrlc_divider import jqrlc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     load,
	input  logic signed [COEF_W-1:0] dividend,
	input  logic [STEP_W-1:0]        divisor,
	output logic                     busy,
	output logic signed [COEF_W-1:0] quotient
);

	localparam int CNT_W = $clog2(COEF_W + 1);

	logic [CNT_W-1:0]  cnt_q;
	logic [COEF_W-1:0] dvd_q;   // dividend bits shift out, quotient bits shift in
	logic [STEP_W-1:0] rem_q;
	logic [STEP_W-1:0] dsr_q;
	logic              neg_q;
	logic [STEP_W:0]   shifted;
	logic [STEP_W-1:0] trial;
	logic              fits;
	logic [COEF_W-1:0] mag;

	// One restoring step: bring down one dividend bit and try a subtract
	assign shifted = {rem_q, dvd_q[COEF_W-1]};
	assign trial   = shifted[STEP_W-1:0] - dsr_q;
	assign fits    = shifted >= {1'b0, dsr_q};
	assign mag     = dividend[COEF_W-1] ? COEF_W'(-dividend) : dividend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= CNT_W'(COEF_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dvd_q <= mag;
			rem_q <= '0;
			dsr_q <= (divisor == '0) ? STEP_W'(1) : divisor;
			neg_q <= dividend[COEF_W-1];
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[COEF_W-2:0], fits};
			rem_q <= fits ? trial : shifted[STEP_W-1:0];
		end
	end

	assign busy     = cnt_q != '0;
	// Apply sign: truncation toward zero
	assign quotient = neg_q ? COEF_W'(-dvd_q) : dvd_q;

endmodule

>>> rtl/core/jqrlc_datapath.sv
module jqrlc_datapath import jqrlc_pkg::*; #(
	parameter int BLOCK_COEFFS   = BLOCK_COEFFS_DEF,
	parameter int NUM_COMPONENTS = NUM_COMPONENTS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cmd_t                     cmd,
	output status_t                  status,
	input  logic [COMP_W-1:0]        component,
	input  logic [TBL_IDX_W-1:0]     table_position,
	input  logic [STEP_W-1:0]        quant_step,
	input  logic signed [COEF_W-1:0] coefficient,
	input  logic                     out_ready,
	output logic                     out_valid,
	output logic [RUN_W-1:0]         out_run_length,
	output logic signed [AMP_W-1:0]  out_amplitude,
	output logic                     out_block_end
);

	localparam int POS_W = $clog2(BLOCK_COEFFS);
	localparam int CMP_W = POS_W + 1;

	logic [POS_W-1:0]         pos_q;
	logic [POS_W-1:0]         zero_run_q;
	logic [COMP_W-1:0]        comp_q;
	logic signed [COEF_W-1:0] coef_q;
	logic signed [COEF_W-1:0] pred_q [NUM_COMPONENTS];
	logic [TBL_ADDR_W-1:0]    waddr;
	logic [TBL_ADDR_W-1:0]    raddr;
	logic [STEP_W-1:0]        wdata;
	logic [STEP_W-1:0]        rdata;
	logic                     div_busy;
	logic signed [COEF_W-1:0] q;
	logic signed [COEF_W-1:0] prev;
	logic signed [AMP_W-1:0]  dc_diff;
	logic                     dc;
	logic                     last;
	logic                     q_zero;
	logic                     out_free;
	logic                     load;
	logic [RUN_W-1:0]         nxt_run;
	logic signed [AMP_W-1:0]  nxt_amp;
	logic                     nxt_end;
	logic                     out_valid_q;
	logic [RUN_W-1:0]         run_q;
	logic signed [AMP_W-1:0]  amp_q;
	logic                     end_q;

	// Quantization table: luma half and shared chroma half
	assign waddr = {component != COMP_LUMA, table_position};
	assign raddr = {component != COMP_LUMA, TBL_IDX_W'(pos_q)};
	assign wdata = (quant_step == '0) ? STEP_W'(1) : quant_step;

	jqrlc_ram #(
		.WIDTH (STEP_W),
		.DEPTH (TBL_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (cmd.tbl_wr),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	jqrlc_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (cmd.div_load),
		.dividend (coef_q),
		.divisor  (rdata),
		.busy     (div_busy),
		.quotient (q)
	);

	// Hold the coefficient being coded
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			comp_q <= component;
			coef_q <= coefficient;
		end
	end

	// Select the DC predictor of this component; unknown components predict zero
	always_comb begin
		prev = '0;
		for (int i = 0; i < NUM_COMPONENTS; i++) begin
			if (comp_q == COMP_W'(i)) begin
				prev = pred_q[i];
			end
		end
	end

	assign dc_diff  = {q[COEF_W-1], q} - {prev[COEF_W-1], prev};
	assign dc       = pos_q == '0;
	assign last     = pos_q == POS_W'(BLOCK_COEFFS - 1);
	assign q_zero   = q == '0;
	assign out_free = !out_valid_q || out_ready;

	// Update predictor on the DC coefficient
	for (genvar g = 0; g < NUM_COMPONENTS; g++) begin : g_pred
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pred_q[g] <= '0;
			end else if (cmd.finish && dc && comp_q == COMP_W'(g)) begin
				pred_q[g] <= q;
			end
		end
	end

	// Advance block position and zero run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			zero_run_q <= '0;
		end else if (cmd.emit_zrl) begin
			zero_run_q <= zero_run_q - POS_W'(ZRL_SPAN);
		end else if (cmd.finish) begin
			pos_q      <= last ? '0 : pos_q + POS_W'(1);
			zero_run_q <= (last || dc || !q_zero) ? '0 : zero_run_q + POS_W'(1);
		end
	end

	// Form the next result pair
	always_comb begin
		nxt_run = '0;
		nxt_amp = '0;
		nxt_end = 1'b0;
		if (cmd.emit_zrl) begin
			nxt_run = ZRL_RUN;
		end else if (dc) begin
			nxt_amp = dc_diff;
			nxt_end = last;
		end else if (!q_zero) begin
			nxt_run = zero_run_q[RUN_W-1:0];
			nxt_amp = {{(AMP_W - COEF_W){q[COEF_W-1]}}, q};
			nxt_end = last;
		end else begin
			nxt_end = 1'b1;
		end
	end

	assign load = cmd.emit_zrl || (cmd.finish && (dc || !q_zero || last));

	// Output register: load a result, drop it on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			run_q <= nxt_run;
			amp_q <= nxt_amp;
			end_q <= nxt_end;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_run_length = run_q;
	assign out_amplitude  = amp_q;
	assign out_block_end  = end_q;

	assign status.div_busy    = div_busy;
	assign status.dc          = dc;
	assign status.q_zero      = q_zero;
	assign status.zrl_pending = CMP_W'(zero_run_q) >= CMP_W'(ZRL_SPAN);
	assign status.out_free    = out_free;

endmodule

>>> rtl/core/jqrlc_ctrl.sv
module jqrlc_ctrl import jqrlc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	input  logic    item_func,
	output logic    item_ready,
	input  status_t status,
	output cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_READ   = 4'b0010,
		ST_DIVIDE = 4'b0100,
		ST_EMIT   = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	// Take table writes while idle; sequence one coefficient: table read, divide, send pairs
	always_comb begin
		cmd        = '0;
		item_ready = 1'b0;
		state_nxt  = state_q;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					if (item_func == FUNC_TABLE) begin
						cmd.tbl_wr = 1'b1;
					end else begin
						cmd.capture = 1'b1;
						state_nxt   = ST_READ;
					end
				end
			end
			ST_READ: begin
				cmd.div_load = 1'b1;
				state_nxt    = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				if (!status.div_busy) begin
					state_nxt = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (status.out_free) begin
					if (!status.dc && !status.q_zero && status.zrl_pending) begin
						cmd.emit_zrl = 1'b1;
					end else begin
						cmd.finish = 1'b1;
						state_nxt  = ST_IDLE;
					end
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

>>> rtl/core/jpeg_quantize_run_length_coder.sv
// Channel  Dir  Payload                                                  Transfer
// item     in   func, component, table_position, quant_step, coefficient valid & ready
// result   out  run_length, amplitude, block_end                         valid & ready
//
// A table write is taken in the idle state. A coefficient goes through accept, table
// read, 12 steps of the bit-serial divider and a state to see the quotient, then any
// sixteen-zero run pairs and the final pair (or a zero is counted instead).
// Reset clears the DC predictors, block position and zero run; the table is not cleared.
// A stalled result holds the send; the next item is accepted while the last result waits.
module jpeg_quantize_run_length_coder import jqrlc_pkg::*; #(
	parameter int BLOCK_COEFFS   = BLOCK_COEFFS_DEF,
	parameter int NUM_COMPONENTS = NUM_COMPONENTS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	jqrlc_item_if.sink     item,
	jqrlc_result_if.source result
);

	cmd_t    cmd;
	status_t status;
	logic    item_ready;

	jqrlc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_func  (item.func),
		.item_ready (item_ready),
		.status     (status),
		.cmd        (cmd)
	);

	jqrlc_datapath #(
		.BLOCK_COEFFS   (BLOCK_COEFFS),
		.NUM_COMPONENTS (NUM_COMPONENTS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.component      (item.component),
		.table_position (item.table_position),
		.quant_step     (item.quant_step),
		.coefficient    (item.coefficient),
		.out_ready      (result.ready),
		.out_valid      (result.valid),
		.out_run_length (result.run_length),
		.out_amplitude  (result.amplitude),
		.out_block_end  (result.block_end)
	);

	assign item.ready = item_ready;

endmodule

>>> rtl/core/jqrlc_checker.sv
module jqrlc_checker import jqrlc_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    item_valid,
	input logic                    item_ready,
	input logic                    item_func,
	input logic                    result_valid,
	input logic                    result_ready,
	input logic [RUN_W-1:0]        result_run_length,
	input logic signed [AMP_W-1:0] result_amplitude,
	input logic                    result_block_end
);

	// Stalled result holds its pair
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_run_length)
			&& $stable(result_amplitude) && $stable(result_block_end))
		else $error("stalled result changed");

	// A coefficient transfer keeps the input closed while it is coded
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item_func == FUNC_COEF |=> !item_ready)
		else $error("input open while coefficient in work");

	// A table write leaves the input open
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item_func == FUNC_TABLE |=> item_ready)
		else $error("table write closed input");

	// A short run always comes with a nonzero value
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_run_length != '0 && result_run_length != ZRL_RUN
			|-> result_amplitude != '0)
		else $error("run pair with zero value");

	// A sixteen-zero run never closes a block
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_run_length == ZRL_RUN && result_amplitude == '0
			|-> !result_block_end)
		else $error("zero run pair marks block end");

endmodule

bind jpeg_quantize_run_length_coder jqrlc_checker u_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.item_valid        (item.valid),
	.item_ready        (item.ready),
	.item_func         (item.func),
	.result_valid      (result.valid),
	.result_ready      (result.ready),
	.result_run_length (result.run_length),
	.result_amplitude  (result.amplitude),
	.result_block_end  (result.block_end)
);
